[design/chacha_pkg.sv]
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared constants, types and the quarter-round function for the ChaCha20
// byte stream XOR block.
// ----------------------------------------------------------------------------
package chacha_pkg;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int NUM_WORDS     = 16;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int NUM_QR        = DOUBLE_ROUNDS * 8;
  localparam int QR_CNT_W      = $clog2(NUM_QR);
  localparam int KS_BYTES      = 64;
  localparam int OFF_W         = $clog2(KS_BYTES);

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    CFG_KEY_0_7     = 3'd0,
    CFG_KEY_8_15    = 3'd1,
    CFG_KEY_16_23   = 3'd2,
    CFG_KEY_24_31   = 3'd3,
    CFG_NONCE_0_7   = 3'd4,
    CFG_NONCE_8_11  = 3'd5,
    CFG_START_CTR   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic qr_t qround(input qr_t x);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    qr_t   r;
    a = x.a + x.b;
    d = x.d ^ a;
    d = {d[15:0], d[31:16]};
    c = x.c + d;
    b = x.b ^ c;
    b = {b[19:0], b[31:20]};
    a = a + b;
    d = d ^ a;
    d = {d[23:0], d[31:24]};
    c = c + d;
    b = b ^ c;
    b = {b[24:0], b[31:25]};
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    return r;
  endfunction

endpackage

[design/chacha20_stream_xor.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// Byte-serial ChaCha20 (20 rounds, 256-bit key, 96-bit nonce, 32-bit counter)
// keystream XOR with one shared quarter-round unit.
// ----------------------------------------------------------------------------
// A byte that falls inside an already computed keystream block is accepted,
// then loaded into the output register from ST_EMIT. The first byte of a
// message and the first byte of every 64-byte block is accepted and loads
// the initial state, then makes 80 passes through the single quarter-round
// unit (one quarter-round per cycle, 20 rounds of 4), the feed-forward add
// and the load of the output register. The output register holds a finished
// result while the next byte is accepted. The user must write key, nonce and
// start counter through the cfg port only while idle; the block itself does
// not enforce it. The counter reloads from start_ctr_q at each message start.
module chacha20_stream_xor
  import chacha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  result_byte_o,
  output logic        result_last_o
);

  // configuration
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce0_q;
  logic [31:0] nonce1_q, start_ctr_q;

  // control
  state_e              state_q, state_d;
  logic [QR_CNT_W-1:0] qr_cnt_q;
  logic [OFF_W-1:0]    offset_q;
  logic                in_message_q;
  word_t               blk_ctr_q;
  logic                out_valid_q;

  // datapath
  word_t       st_q [NUM_WORDS];
  word_t       st_d [NUM_WORDS];
  word_t       tmp  [NUM_WORDS];
  word_t       base_w [NUM_WORDS];
  word_t       cur_ctr_q;
  word_t       ld_ctr;
  logic [7:0]  data_q;
  logic        last_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  qr_t         qr_in, qr_out;
  logic [1:0]  amt [4];
  word_t       ks_word;
  logic [7:0]  ks_byte;

  logic acc, need_blk, ld_init, do_round, do_final, emit_fire, qr_last;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q      <= '0;
      key1_q      <= '0;
      key2_q      <= '0;
      key3_q      <= '0;
      nonce0_q    <= '0;
      nonce1_q    <= '0;
      start_ctr_q <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_0_7:    key0_q      <= cfg_wdata_i;
        CFG_KEY_8_15:   key1_q      <= cfg_wdata_i;
        CFG_KEY_16_23:  key2_q      <= cfg_wdata_i;
        CFG_KEY_24_31:  key3_q      <= cfg_wdata_i;
        CFG_NONCE_0_7:  nonce0_q    <= cfg_wdata_i;
        CFG_NONCE_8_11: nonce1_q    <= cfg_wdata_i[31:0];
        CFG_START_CTR:  start_ctr_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // FSM outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    acc        = in_valid_i && (state_q == ST_IDLE);
    need_blk   = !in_message_q || (offset_q == '0);
    ld_init    = acc && need_blk;
    do_round   = (state_q == ST_ROUND);
    do_final   = (state_q == ST_FINAL);
    emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
    qr_last    = (qr_cnt_q == QR_CNT_W'(NUM_QR - 1));
  end

  // --------------------------------------------------------------------------
  // FSM next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (acc) state_d = need_blk ? ST_ROUND : ST_EMIT;
      ST_ROUND: if (qr_last) state_d = ST_FINAL;
      ST_FINAL: state_d = ST_EMIT;
      ST_EMIT:  if (emit_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      qr_cnt_q     <= '0;
      offset_q     <= '0;
      in_message_q <= 1'b0;
      blk_ctr_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_init) begin
        qr_cnt_q  <= '0;
        blk_ctr_q <= ld_ctr + 32'd1;
      end else if (do_round) begin
        qr_cnt_q <= qr_cnt_q + 1'b1;
      end
      if (acc) in_message_q <= 1'b1;
      if (emit_fire) begin
        offset_q     <= last_q ? '0 : offset_q + 1'b1;
        in_message_q <= !last_q;
      end
      if (emit_fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // state words: load, quarter-round with fixed-wiring permute, feed-forward
  // --------------------------------------------------------------------------
  always_comb begin
    base_w[0]  = SIGMA0;
    base_w[1]  = SIGMA1;
    base_w[2]  = SIGMA2;
    base_w[3]  = SIGMA3;
    base_w[4]  = key0_q[31:0];
    base_w[5]  = key0_q[63:32];
    base_w[6]  = key1_q[31:0];
    base_w[7]  = key1_q[63:32];
    base_w[8]  = key2_q[31:0];
    base_w[9]  = key2_q[63:32];
    base_w[10] = key3_q[31:0];
    base_w[11] = key3_q[63:32];
    base_w[12] = cur_ctr_q;
    base_w[13] = nonce0_q[31:0];
    base_w[14] = nonce0_q[63:32];
    base_w[15] = nonce1_q;
  end

  assign ld_ctr = in_message_q ? blk_ctr_q : start_ctr_q;

  assign qr_in  = '{a: st_q[0], b: st_q[4], c: st_q[8], d: st_q[12]};
  assign qr_out = qround(qr_in);

  // Column 0 always feeds the unit. Rows rotate left by one after each
  // quarter-round; the fourth step of a round also (un)diagonalizes.
  always_comb begin
    if (qr_cnt_q[1:0] != 2'd3) begin
      amt[0] = 2'd1;
      amt[1] = 2'd1;
      amt[2] = 2'd1;
      amt[3] = 2'd1;
    end else if (!qr_cnt_q[2]) begin
      amt[0] = 2'd1;
      amt[1] = 2'd2;
      amt[2] = 2'd3;
      amt[3] = 2'd0;
    end else begin
      amt[0] = 2'd1;
      amt[1] = 2'd0;
      amt[2] = 2'd3;
      amt[3] = 2'd2;
    end
  end

  always_comb begin
    tmp     = st_q;
    tmp[0]  = qr_out.a;
    tmp[4]  = qr_out.b;
    tmp[8]  = qr_out.c;
    tmp[12] = qr_out.d;
    st_d    = st_q;
    if (ld_init) begin
      st_d     = base_w;
      st_d[12] = ld_ctr;
    end else if (do_round) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          st_d[r*4 + c] = tmp[{2'(r), 2'(c) + amt[r]}];
        end
      end
    end else if (do_final) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        st_d[i] = st_q[i] + base_w[i];
      end
    end
  end

  assign ks_word = st_q[offset_q[5:2]];
  assign ks_byte = ks_word[{offset_q[1:0], 3'b000} +: 8];

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (ld_init) cur_ctr_q <= ld_ctr;
    if (acc) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (emit_fire) begin
      out_byte_q <= data_q ^ ks_byte;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = out_byte_q;
  assign result_last_o = out_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_round_to_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) && qr_last |=> (state_q == ST_FINAL))
    else $error("round count did not end in feed-forward");

  a_qr_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (qr_cnt_q < QR_CNT_W'(NUM_QR)))
    else $error("quarter-round counter out of range");

  a_mid_block_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_message_q && (offset_q != '0) |=> (state_q == ST_EMIT))
    else $error("keystream recomputed inside a block");

  a_last_ends_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && last_q |=> !in_message_q && (offset_q == '0))
    else $error("last byte did not end the message");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> out_valid_o && (result_last_o == $past(last_q)))
    else $error("result not presented after emit");

endmodule

[tb/chacha20_stream_xor_tb.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_xor_tb
// Self-checking bench for the byte-serial ChaCha20 keystream XOR. Bytes go in
// as messages on the valid/stall input channel. A local model computes the
// keystream blocks from the shadow key, nonce and counter registers and
// predicts each result byte. Results are matched in order on the output
// channel. The run starts with a short table of directed bytes and register
// writes, then switches between register settings across phases of random
// messages, with random idle cycles on both sides and one long output stall.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_tb
  import chacha_pkg::*;
();

  localparam int          CYCLE_LIMIT    = 1_000_000;
  localparam int          IDLE_SETTLE    = 100;    // > one full keystream block fill
  localparam int          LONG_HOLD      = 400;
  localparam int          PHASES         = 8;
  localparam int          PHASE_ITEMS    = 230;
  localparam int          DIR_ROWS       = 20;
  localparam logic [2:0]  CFG_IDX_UNUSED = 3'd7;

  localparam int WAIT_SPREAD = 0;
  localparam int WAIT_NONE   = 1;
  localparam int WAIT_RARE   = 2;

  typedef struct packed {
    logic [7:0] res_byte;
    logic       res_last;
  } xor_res_t;

  typedef struct packed {
    logic        do_cfg;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_val;
    logic [7:0]  data;
    logic        last;
    logic        has_exp;
    logic [7:0]  exp_byte;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  result_byte_o;
  logic        result_last_o;

  chacha20_stream_xor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_byte_o (result_byte_o),
    .result_last_o (result_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow registers and keystream model state
  logic [63:0] key_sh [4];
  logic [63:0] nonce_lo_sh;
  word_t       nonce_hi_sh;
  word_t       start_ctr_sh;
  word_t       ks_words [NUM_WORDS];
  word_t       mix_w [NUM_WORDS];
  logic [5:0]  ks_off;
  word_t       blk_ctr;
  logic        msg_open;

  xor_res_t    pending_xor [$];
  int          err_cnt = 0;
  int          cyc_cnt = 0;
  int          snd_mode = WAIT_SPREAD;
  int          snd_left = 0;
  int          snd_burst = 0;
  int          rcv_mode = WAIT_SPREAD;
  int          rcv_left = 0;
  bit          long_hold = 1'b0;

  // Bytes 0..3 of the all-zero key/nonce block at counter 1 are 9f 07 e7 be.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'h00, 1'b0, 1'b1, 8'h9f},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'hff, 1'b0, 1'b1, 8'hf8},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'h00, 1'b0, 1'b1, 8'he7},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'h00, 1'b1, 1'b1, 8'hbe},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'h00, 1'b1, 1'b1, 8'h9f},
    '{1'b1, CFG_IDX_UNUSED, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b1, 1'b1, 8'h9f},
    '{1'b1, CFG_KEY_0_7,    64'hffff_ffff_ffff_ffff, 8'hff, 1'b0, 1'b0, 8'h00},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b1, CFG_KEY_8_15,   64'hffff_ffff_ffff_ffff, 8'h5a, 1'b0, 1'b0, 8'h00},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'ha5, 1'b1, 1'b0, 8'h00},
    '{1'b1, CFG_START_CTR,  64'h0000_0000_ffff_ffff, 8'h00, 1'b1, 1'b0, 8'h00},
    '{1'b1, CFG_NONCE_0_7,  64'hffff_ffff_ffff_ffff, 8'hff, 1'b0, 1'b0, 8'h00},
    '{1'b1, CFG_NONCE_8_11, 64'hffff_ffff_ffff_ffff, 8'h01, 1'b0, 1'b0, 8'h00},
    '{1'b1, CFG_KEY_16_23,  64'hffff_ffff_ffff_ffff, 8'h80, 1'b1, 1'b0, 8'h00},
    '{1'b1, CFG_KEY_24_31,  64'hffff_ffff_ffff_ffff, 8'h7f, 1'b1, 1'b0, 8'h00},
    '{1'b1, CFG_START_CTR,  64'hffff_ffff_0000_0000, 8'h00, 1'b1, 1'b0, 8'h00},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'hff, 1'b0, 1'b0, 8'h00},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, CFG_KEY_0_7,    64'h0,                  8'hff, 1'b1, 1'b0, 8'h00}
  };

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void qr_mix(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void refill_keystream(word_t ctr);
    word_t init_w [NUM_WORDS];
    init_w[0] = SIGMA0;
    init_w[1] = SIGMA1;
    init_w[2] = SIGMA2;
    init_w[3] = SIGMA3;
    for (int j = 0; j < 4; j++) begin
      init_w[4 + 2 * j] = key_sh[j][31:0];
      init_w[5 + 2 * j] = key_sh[j][63:32];
    end
    init_w[12] = ctr;
    init_w[13] = nonce_lo_sh[31:0];
    init_w[14] = nonce_lo_sh[63:32];
    init_w[15] = nonce_hi_sh;
    for (int i = 0; i < NUM_WORDS; i++) mix_w[i] = init_w[i];
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      qr_mix(0, 4, 8, 12);
      qr_mix(1, 5, 9, 13);
      qr_mix(2, 6, 10, 14);
      qr_mix(3, 7, 11, 15);
      qr_mix(0, 5, 10, 15);
      qr_mix(1, 6, 11, 12);
      qr_mix(2, 7, 8, 13);
      qr_mix(3, 4, 9, 14);
    end
    for (int i = 0; i < NUM_WORDS; i++) ks_words[i] = mix_w[i] + init_w[i];
  endfunction

  function automatic xor_res_t chacha_xor_byte(logic [7:0] data, logic last);
    xor_res_t res;
    word_t    kw;
    if (!msg_open) begin
      blk_ctr  = start_ctr_sh;
      ks_off   = '0;
      msg_open = 1'b1;
    end
    if (ks_off == 0) begin
      refill_keystream(blk_ctr);
      blk_ctr = blk_ctr + 32'd1;
    end
    kw = ks_words[ks_off[5:2]] >> (8 * ks_off[1:0]);
    res.res_byte = data ^ kw[7:0];
    res.res_last = last;
    ks_off = ks_off + 6'd1;
    if (last) begin
      ks_off   = '0;
      msg_open = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_wait(int mode);
    case (mode)
      WAIT_NONE: return 0;
      WAIT_RARE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      default:   return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cyc_cnt);
    err_cnt++;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_KEY_0_7:    key_sh[0]    = val;
      CFG_KEY_8_15:   key_sh[1]    = val;
      CFG_KEY_16_23:  key_sh[2]    = val;
      CFG_KEY_24_31:  key_sh[3]    = val;
      CFG_NONCE_0_7:  nonce_lo_sh  = val;
      CFG_NONCE_8_11: nonce_hi_sh  = val[31:0];
      CFG_START_CTR:  start_ctr_sh = val[31:0];
      default: ;
    endcase
  endtask

  // drain all results, then give the block time to finish any block fill
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_xor.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic send_item(logic [7:0] data, logic last, bit has_exp, logic [7:0] exp_byte);
    int       gap;
    xor_res_t res;
    if (snd_left == 0) begin
      snd_mode = $urandom_range(0, 2);
      snd_left = 50;
    end
    snd_left--;
    if (snd_burst > 0) begin
      snd_burst--;
      gap = 0;
    end else begin
      gap = pick_wait(snd_mode);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = chacha_xor_byte(data, last);
    if (has_exp) res.res_byte = exp_byte;
    pending_xor.push_back(res);
  endtask

  task automatic run_directed();
    dir_row_t row;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (row.do_cfg) begin
        wait_idle();
        cfg_write(row.cfg_idx, row.cfg_val);
        cfg_we_i <= 1'b0;
      end
      send_item(row.data, row.last, row.has_exp, row.exp_byte);
    end
  endtask

  task automatic setup_phase(int p);
    logic [63:0] val;
    for (int j = 0; j < 7; j++) begin
      case (p)
        0: val = (j == CFG_START_CTR) ? {$urandom(), 32'hffff_ffff} : 64'h0;
        1: val = (j == CFG_START_CTR) ? {$urandom(), 32'h0} : 64'hffff_ffff_ffff_ffff;
        default: begin
          val = {$urandom(), $urandom()};
          if (j == CFG_START_CTR && $urandom_range(0, 2) == 0) val[31:0] = 32'hffff_fffe;
        end
      endcase
      cfg_write(j[2:0], val);
    end
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_IDX_UNUSED, {$urandom(), $urandom()});
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random();
    int len;
    int cnt;
    int r;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      setup_phase(p);
      if (p == 3) begin
        long_hold = 1'b1;
        snd_burst = 80;
      end
      cnt = 0;
      // first message of a phase crosses at least one block boundary
      len = $urandom_range(65, 140);
      while (cnt < PHASE_ITEMS) begin
        for (int k = 0; k < len; k++) begin
          send_item(8'($urandom_range(0, 255)), k == len - 1, 1'b0, 8'h00);
          cnt++;
        end
        r = $urandom_range(0, 19);
        if (r < 14)      len = $urandom_range(1, 12);
        else if (r < 19) len = $urandom_range(13, 64);
        else             len = $urandom_range(65, 200);
      end
    end
  endtask

  // output side
  initial begin
    int       hold_n;
    xor_res_t want;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rcv_left == 0) begin
        rcv_mode = $urandom_range(0, 2);
        rcv_left = 50;
      end
      rcv_left--;
      if (long_hold) begin
        long_hold = 1'b0;
        hold_n    = LONG_HOLD;
      end else begin
        hold_n = pick_wait(rcv_mode);
      end
      if (hold_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_xor.size() == 0) begin
        report_mismatch("unexpected result_byte", 64'(result_byte_o), 64'h0);
      end else begin
        want = pending_xor.pop_front();
        if (result_byte_o !== want.res_byte)
          report_mismatch("result_byte", 64'(result_byte_o), 64'(want.res_byte));
        if (result_last_o !== want.res_last)
          report_mismatch("result_last", 64'(result_last_o), 64'(want.res_last));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("chacha20_stream_xor test failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    for (int j = 0; j < 4; j++) key_sh[j] = '0;
    nonce_lo_sh  = '0;
    nonce_hi_sh  = '0;
    start_ctr_sh = 32'd1;
    ks_off       = '0;
    blk_ctr      = '0;
    msg_open     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    wait_idle();
    if (pending_xor.size() == 0 && err_cnt == 0) begin
      $display("chacha20_stream_xor test passed");
    end else begin
      $display("chacha20_stream_xor test failed");
    end
    $finish;
  end

endmodule
